FILE: hw/rtl/r2fft_pkg.sv
`default_nettype none
package r2fft_pkg;

    localparam int MAX_LOG2_POINTS = 6;
    localparam int MAX_POINTS      = 1 << MAX_LOG2_POINTS;
    localparam int SAMPLE_BITS     = 16;
    localparam int TWIDDLE_BITS    = 16;
    localparam int RESULT_BITS     = SAMPLE_BITS + MAX_LOG2_POINTS;
    localparam int PROD_BITS       = RESULT_BITS + TWIDDLE_BITS;
    localparam int ADDR_BITS       = MAX_LOG2_POINTS;
    localparam int LG_BITS         = 3;
    localparam int CNT_BITS        = 7;

    // register indexes
    localparam logic [1:0] REG_LOG2_POINTS    = 2'd0;
    localparam logic [1:0] REG_INVERSE_MODE   = 2'd1;
    localparam logic [1:0] REG_ZERO_THRESHOLD = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_E,
        ST_RD_O,
        ST_MUL,
        ST_WR_E,
        ST_WR_O,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                 load_wr;
        logic [ADDR_BITS-1:0] load_addr;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 lat_e;
        logic                 mul;
        logic                 wr_e;
        logic                 wr_o;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [ADDR_BITS-1:0] tw_idx;
        logic                 first;
        logic                 out_valid;
        logic [ADDR_BITS-1:0] out_bin;
        logic                 out_last;
        logic [LG_BITS-1:0]   lg;
    } cmd_t;

    // bit reversal of an index over lg bits
    function automatic logic [ADDR_BITS-1:0] bit_rev(input logic [ADDR_BITS-1:0] i,
                                                      input logic [LG_BITS-1:0] lg);
        logic [ADDR_BITS-1:0] r;
        r = '0;
        for (int b = 0; b < ADDR_BITS; b++)
        begin
            if (b < int'(lg))
                r[int'(lg) - 1 - b] = i[b];
        end
        return r;
    endfunction

    // quarter cosine table, Q1.30
    function automatic logic signed [31:0] cos_q30(input logic [4:0] j);
        logic signed [31:0] v;
        case (j)
            5'd0:  v = 32'sd1073741824;
            5'd1:  v = 32'sd1068571464;
            5'd2:  v = 32'sd1053110176;
            5'd3:  v = 32'sd1027506862;
            5'd4:  v = 32'sd992008094;
            5'd5:  v = 32'sd946955747;
            5'd6:  v = 32'sd892783698;
            5'd7:  v = 32'sd830013654;
            5'd8:  v = 32'sd759250125;
            5'd9:  v = 32'sd681174650;
            5'd10: v = 32'sd596538995;
            5'd11: v = 32'sd506158392;
            5'd12: v = 32'sd410903207;
            5'd13: v = 32'sd311690799;
            5'd14: v = 32'sd209476638;
            5'd15: v = 32'sd105245103;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // cos(2*pi*j/64) at TWIDDLE_BITS, rounded, saturated
    function automatic logic signed [TWIDDLE_BITS-1:0] rom_cos(input logic [5:0] j);
        logic signed [32:0] m;
        logic signed [32:0] r;
        if (j <= 6'd16)
            m = 33'(cos_q30(5'(j)));
        else if (j <= 6'd32)
            m = -33'(cos_q30(5'(6'd32 - j)));
        else if (j <= 6'd48)
            m = -33'(cos_q30(5'(j - 6'd32)));
        else
            m = 33'(cos_q30(5'(7'd64 - 7'(j))));
        r = (m + (33'sd1 <<< (30 - TWIDDLE_BITS))) >>> (31 - TWIDDLE_BITS);
        if (r > 33'sd2 ** (TWIDDLE_BITS - 1) - 33'sd1)
            r = 33'sd2 ** (TWIDDLE_BITS - 1) - 33'sd1;
        return r[TWIDDLE_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/r2fft_ctrl.sv
`default_nettype none
module r2fft_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [2:0]             log2_points,
    output logic                        busy,
    output r2fft_pkg::cmd_t             cmd
);

    localparam int AB = r2fft_pkg::ADDR_BITS;

    r2fft_pkg::state_t state_reg, state_next;
    logic [r2fft_pkg::CNT_BITS-1:0] load_count_reg, load_count_next;
    logic [r2fft_pkg::LG_BITS-1:0]  lg_reg, lg_next;
    logic [r2fft_pkg::LG_BITS-1:0]  stage_reg, stage_next;  // stage - 1
    logic [AB-1:0]                  bfly_reg, bfly_next;    // butterfly number
    logic [AB:0]                    out_reg, out_next;

    logic [r2fft_pkg::LG_BITS-1:0] lg_cfg;
    logic [r2fft_pkg::LG_BITS-1:0] sh;
    logic [AB-1:0] half, jj, grp, e_addr, o_addr, last_bfly, nm1;
    logic [r2fft_pkg::CNT_BITS-1:0] n_pts;

    assign lg_cfg = (log2_points > 3'(r2fft_pkg::MAX_LOG2_POINTS)) ?
                    3'(r2fft_pkg::MAX_LOG2_POINTS) : log2_points;
    assign n_pts  = 7'd1 << lg_cfg;

    // entry i of an N-point block sits at store address i << (6 - lg)
    assign sh = 3'(AB) - lg_reg;

    // butterfly addressing for current stage
    assign half      = AB'(1) << stage_reg;
    assign jj        = bfly_reg & (half - AB'(1));
    assign grp       = (bfly_reg >> stage_reg) << (stage_reg + 3'd1);
    assign e_addr    = grp | jj;
    assign o_addr    = e_addr | half;
    assign last_bfly = AB'((7'd1 << lg_reg) >> 1) - AB'(1);
    assign nm1       = AB'((7'd1 << lg_reg) - 7'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= r2fft_pkg::ST_LOAD;
            load_count_reg <= '0;
            lg_reg         <= '0;
            stage_reg      <= '0;
            bfly_reg       <= '0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            lg_reg         <= lg_next;
            stage_reg      <= stage_next;
            bfly_reg       <= bfly_next;
            out_reg        <= out_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        lg_next         = lg_reg;
        stage_next      = stage_reg;
        bfly_next       = bfly_reg;
        out_next        = out_reg;
        busy            = 1'b1;
        cmd             = '0;
        cmd.lg          = lg_reg;
        cmd.first       = (stage_reg == '0);
        cmd.tw_idx      = AB'(jj << (3'(AB) - 3'd1 - stage_reg));
        case (state_reg)
            r2fft_pkg::ST_LOAD:
            begin
                busy          = 1'b0;
                cmd.load_addr = AB'(load_count_reg);
                cmd.load_wr   = start;
                if (start)
                begin
                    if (load_count_reg + 7'd1 >= n_pts)
                    begin
                        load_count_next = '0;
                        lg_next         = lg_cfg;
                        stage_next      = '0;
                        bfly_next       = '0;
                        out_next        = '0;
                        state_next      = (lg_cfg == 3'd0) ? r2fft_pkg::ST_OUT_RD
                                                           : r2fft_pkg::ST_RD_E;
                    end
                    else
                        load_count_next = load_count_reg + 7'd1;
                end
            end
            r2fft_pkg::ST_RD_E:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = e_addr << sh;
                state_next  = r2fft_pkg::ST_RD_O;
            end
            r2fft_pkg::ST_RD_O:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = o_addr << sh;
                cmd.lat_e   = 1'b1;
                state_next  = r2fft_pkg::ST_MUL;
            end
            r2fft_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = r2fft_pkg::ST_WR_E;
            end
            r2fft_pkg::ST_WR_E:
            begin
                cmd.wr_e    = 1'b1;
                cmd.wr_addr = e_addr << sh;
                state_next  = r2fft_pkg::ST_WR_O;
            end
            r2fft_pkg::ST_WR_O:
            begin
                cmd.wr_o    = 1'b1;
                cmd.wr_addr = o_addr << sh;
                state_next  = r2fft_pkg::ST_RD_E;
                if (bfly_reg == last_bfly)
                begin
                    bfly_next = '0;
                    if (stage_reg == lg_reg - 3'd1)
                        state_next = r2fft_pkg::ST_OUT_RD;
                    else
                        stage_next = stage_reg + 3'd1;
                end
                else
                    bfly_next = bfly_reg + AB'(1);
            end
            r2fft_pkg::ST_OUT_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = AB'(out_reg) << sh;
                state_next  = r2fft_pkg::ST_OUT;
            end
            r2fft_pkg::ST_OUT:
            begin
                cmd.out_valid = 1'b1;
                cmd.out_bin   = AB'(out_reg);
                cmd.out_last  = (AB'(out_reg) == nm1);
                if (AB'(out_reg) == nm1)
                    state_next = r2fft_pkg::ST_LOAD;
                else
                begin
                    out_next   = out_reg + (AB+1)'(1);
                    state_next = r2fft_pkg::ST_OUT_RD;
                end
            end
            default:
                state_next = r2fft_pkg::ST_LOAD;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/r2fft_dp.sv
`default_nettype none
module r2fft_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  r2fft_pkg::cmd_t                            cmd,
    input  wire logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_re,
    input  wire logic signed [r2fft_pkg::SAMPLE_BITS-1:0] sample_im,
    input  wire logic                                  inverse_mode,
    input  wire logic [15:0]                           zero_threshold,
    output logic signed [r2fft_pkg::RESULT_BITS-1:0]   result_re,
    output logic signed [r2fft_pkg::RESULT_BITS-1:0]   result_im,
    output logic [r2fft_pkg::ADDR_BITS-1:0]            bin_index,
    output logic                                       last_result,
    output logic                                       result_valid
);

    localparam int RB = r2fft_pkg::RESULT_BITS;
    localparam int PB = r2fft_pkg::PROD_BITS;
    localparam int TB = r2fft_pkg::TWIDDLE_BITS;

    // raw samples at full-width bit-reversed addresses; an N-point block
    // uses every (64/N)-th entry
    logic [2*RB-1:0] mem [r2fft_pkg::MAX_POINTS];
    logic [2*RB-1:0] rd_data_reg;
    logic signed [RB-1:0] e_re_reg, e_im_reg;
    logic signed [RB-1:0] o_re_w, ld_im, cj_im;
    logic                 conj;
    logic signed [PB-1:0] pr1_reg, pr2_reg, pi1_reg, pi2_reg;
    logic signed [RB-1:0] lo_re_reg, lo_im_reg;
    logic signed [TB-1:0] wr_w, wi_w;
    logic signed [PB:0]   tr, ti;
    logic signed [RB+1:0] sum_re, sum_im, dif_re, dif_im;
    logic signed [RB-1:0] st_re, st_im;
    logic [2*RB-1:0]      wdata;
    logic [r2fft_pkg::ADDR_BITS-1:0] waddr;
    logic                 we;
    logic signed [RB-1:0] out_re, out_im;
    logic                 valid_reg;
    logic signed [RB-1:0] res_re_reg, res_im_reg;
    logic [r2fft_pkg::ADDR_BITS-1:0] bin_reg;
    logic                 last_reg;

    function automatic logic signed [RB-1:0] sat(input logic signed [RB+1:0] v);
        logic signed [RB+1:0] hi;
        hi = (RB+2)'((1 << (RB - 1)) - 1);
        if (v > hi)
            return hi[RB-1:0];
        else if (v < -hi - (RB+2)'(1))
            return {1'b1, {(RB-1){1'b0}}};
        else
            return v[RB-1:0];
    endfunction

    function automatic logic signed [RB-1:0] fin(input logic signed [RB-1:0] v,
                                                   input logic [15:0] th);
        logic [RB:0] a;
        a = v[RB-1] ? -(RB+1)'(v) : (RB+1)'(v);
        return (a < (RB+1)'(th)) ? '0 : v;
    endfunction

    assign wr_w = r2fft_pkg::rom_cos(cmd.tw_idx);
    assign wi_w = -r2fft_pkg::rom_cos(cmd.tw_idx + 6'd48);

    // inverse mode conjugates the raw samples as the first stage reads them
    assign conj   = inverse_mode & cmd.first;
    assign o_re_w = rd_data_reg[2*RB-1:RB];
    assign ld_im  = rd_data_reg[RB-1:0];
    assign cj_im  = conj ? -ld_im : ld_im;

    // complex product, rounded once
    assign tr = ((PB+1)'(pr1_reg) - (PB+1)'(pr2_reg) + ((PB+1)'(1) <<< (TB - 2)))
                >>> (TB - 1);
    assign ti = ((PB+1)'(pi1_reg) + (PB+1)'(pi2_reg) + ((PB+1)'(1) <<< (TB - 2)))
                >>> (TB - 1);
    assign sum_re = (RB+2)'(e_re_reg) + (RB+2)'(tr);
    assign sum_im = (RB+2)'(e_im_reg) + (RB+2)'(ti);
    assign dif_re = (RB+2)'(e_re_reg) - (RB+2)'(tr);
    assign dif_im = (RB+2)'(e_im_reg) - (RB+2)'(ti);

    // store write select
    always_comb
    begin
        we    = cmd.load_wr | cmd.wr_e | cmd.wr_o;
        waddr = cmd.wr_addr;
        wdata = {lo_re_reg, lo_im_reg};
        if (cmd.load_wr)
        begin
            waddr = r2fft_pkg::bit_rev(cmd.load_addr, 3'(r2fft_pkg::MAX_LOG2_POINTS));
            st_re = RB'(sample_re);
            st_im = RB'(sample_im);
            wdata = {st_re, st_im};
        end
        else
        begin
            st_re = '0;
            st_im = '0;
            if (cmd.wr_e)
                wdata = {sat(sum_re), sat(sum_im)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
    end

    // butterfly pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.lat_e)
        begin
            e_re_reg <= rd_data_reg[2*RB-1:RB];
            e_im_reg <= cj_im;
        end
        if (cmd.mul)
        begin
            pr1_reg <= o_re_w * wr_w;
            pr2_reg <= cj_im * wi_w;
            pi1_reg <= o_re_w * wi_w;
            pi2_reg <= cj_im * wr_w;
        end
        if (cmd.wr_e)
        begin
            lo_re_reg <= sat(dif_re);
            lo_im_reg <= sat(dif_im);
        end
    end

    // output conditioning; a one-point block never passed a stage, so
    // its samples were never conjugated
    always_comb
    begin
        out_re = rd_data_reg[2*RB-1:RB];
        out_im = rd_data_reg[RB-1:0];
        if (inverse_mode && cmd.lg != '0)
        begin
            out_im = (-out_im) >>> cmd.lg;
            out_re = out_re >>> cmd.lg;
            if (rd_data_reg[RB-1:0] == {1'b1, {(RB-1){1'b0}}})
                out_im = RB'(((RB+1)'(1) <<< (RB - 1)) >>> cmd.lg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.out_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_valid)
        begin
            res_re_reg <= fin(out_re, zero_threshold);
            res_im_reg <= fin(out_im, zero_threshold);
            bin_reg    <= cmd.out_bin;
            last_reg   <= cmd.out_last;
        end
    end

    assign result_re    = res_re_reg;
    assign result_im    = res_im_reg;
    assign bin_index    = bin_reg;
    assign last_result  = last_reg;
    assign result_valid = valid_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/radix2_fft_ifft.sv
`default_nettype none
// Radix-2 decimation-in-time FFT / IFFT, up to 64 complex points.
// Samples: pulse start with sample_re/sample_im while busy is low; one
// transfer per accepted cycle, stored bit-reversed. The N-th transfer
// starts the transform and busy rises.
// Transform: one shared butterfly unit; each butterfly takes two store
// reads, one multiply stage and two store writes, in that order.
// Results: N bins in natural order, each read from the store and then
// registered at the output, shown for one cycle with result_valid high;
// last_result marks bin N-1. The receiver cannot stall. Configuration:
// cfg_we/cfg_index/cfg_data; the user must see that it is written only
// while idle, as the block itself does not enforce it. Reset clears the
// load count and resets control, configuration and valid registers;
// store contents are undefined until written and need no clearing.
module radix2_fft_ifft (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic signed [15:0]  sample_re,
    input  wire logic signed [15:0]  sample_im,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    output logic                     result_valid,
    output logic signed [21:0]       result_re,
    output logic signed [21:0]       result_im,
    output logic [5:0]               bin_index,
    output logic                     last_result
);

    logic [2:0]  log2_points_reg;
    logic        inverse_mode_reg;
    logic [15:0] zero_threshold_reg;
    r2fft_pkg::cmd_t cmd;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_points_reg    <= 3'd6;
            inverse_mode_reg   <= 1'b0;
            zero_threshold_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                r2fft_pkg::REG_LOG2_POINTS:    log2_points_reg    <= cfg_data[2:0];
                r2fft_pkg::REG_INVERSE_MODE:   inverse_mode_reg   <= cfg_data[0];
                r2fft_pkg::REG_ZERO_THRESHOLD: zero_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    r2fft_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .log2_points (log2_points_reg),
        .busy        (busy),
        .cmd         (cmd)
    );

    r2fft_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sample_re      (sample_re),
        .sample_im      (sample_im),
        .inverse_mode   (inverse_mode_reg),
        .zero_threshold (zero_threshold_reg),
        .result_re      (result_re),
        .result_im      (result_im),
        .bin_index      (bin_index),
        .last_result    (last_result),
        .result_valid   (result_valid)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/r2fft_checker.sv
`default_nettype none
module r2fft_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic busy,
    input wire logic result_valid,
    input wire logic last_result,
    input wire logic [5:0] bin_index
);

    // bins before the last one only appear while busy
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> busy) else $error("result while idle");

    // results never come back to back
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("back to back results");

    // the last bin shows once the block is idle again
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_result) |-> !busy) else $error("not idle at last");

    // bins count up by one
    a_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |=> ##1 (result_valid &&
        bin_index == $past(bin_index, 2) + 6'd1)) else $error("bin order");

endmodule

bind radix2_fft_ifft r2fft_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .last_result  (last_result),
    .bin_index    (bin_index)
);
`default_nettype wire
